// ----- src/gsbd_pkg.sv -----
// ----------------------------------------------------------------------------
// gsbd_pkg: graph search shared types and constants
// Field widths and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package gsbd_pkg;

  localparam int NODE_W = 4;
  localparam int ROW_W  = 16;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 5;

  localparam logic [0:0] REQ_LOAD   = 1'b0;
  localparam logic [0:0] REQ_SEARCH = 1'b1;

  localparam logic [0:0] CFG_NODE_COUNT  = 1'b0;
  localparam logic [0:0] CFG_SEARCH_MODE = 1'b1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef struct packed {
    logic load_row;
    logic start;
    logic emit_bad;
    logic fetch;
    logic row_read;
    logic push;
    logic pop;
    logic finish;
  } gsbd_cmd_t;

  typedef struct packed {
    logic bad_start;
    logic empty;
    logic cand_any;
    logic out_free;
    logic dfs;
  } gsbd_status_t;

endpackage

// ----- src/graph_search_bfs_dfs.sv -----
// ----------------------------------------------------------------------------
// graph_search_bfs_dfs: breadth/depth first search over an adjacency matrix
// Request channel (req_valid/req_stall) takes row loads and search starts.
// A load gives no result; loads may stream.
// Any request is held off (req_stall) while a search is running.
// Result channel (res_valid/res_stall) gives visited nodes in visit order,
// the start node first, last_visit on the final one. A bad start node
// gives one result with bad_start and last_visit set.
// Each pass over the pending store goes through fetch, adjacency row read
// (both registered memory reads) and a scan. Breadth first fetches each
// node found once and scans its row until no unvisited neighbor is left.
// Depth first fetches again after every push and every pop. Result stalls
// hold back the scan and the final emit in both modes.
// The result register frees the search loop: a new node waits only while
// the previous one is still held by res_stall.
// cfg_ready is always high; write registers only while idle.
// Reset clears the controller, pointers, result valid and the registers
// (node_count 16, search_mode 0). Adjacency rows are undefined until loaded.
// ----------------------------------------------------------------------------
module graph_search_bfs_dfs #(
  parameter int MAX_NODES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [gsbd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [gsbd_pkg::NODE_W-1:0] row_index,
  input  logic [gsbd_pkg::ROW_W-1:0]  row_bits,
  input  logic [gsbd_pkg::NODE_W-1:0] start_node,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [gsbd_pkg::NODE_W-1:0] visited_node,
  output logic                        last_visit,
  output logic                        bad_start
);
  import gsbd_pkg::*;

  gsbd_cmd_t    cmd;
  gsbd_status_t status;

  assign cfg_ready = 1'b1;

  gsbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gsbd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .start_node   (start_node),
    .cmd          (cmd),
    .status       (status),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .visited_node (visited_node),
    .last_visit   (last_visit),
    .bad_start    (bad_start)
  );

endmodule

// ----- src/gsbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gsbd_ctrl: graph search controller
// Sequences load, bad start emit, fetch, row read, neighbor scan and final emit.
// ----------------------------------------------------------------------------
module gsbd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_type,
  output logic                  req_stall,
  input  gsbd_pkg::gsbd_status_t status,
  output gsbd_pkg::gsbd_cmd_t    cmd
);
  import gsbd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_ROW   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       is_search;

  assign is_search = (req_type == REQ_SEARCH);
  assign req_stall = (state != ST_IDLE) ||
                     (req_valid && is_search && status.bad_start && !status.out_free);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!is_search) begin
            cmd.load_row = 1'b1;
          end else if (status.bad_start) begin
            cmd.emit_bad = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (status.empty) begin
          state_next = ST_DONE;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_read = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.cand_any) begin
          cmd.pop    = status.dfs;
          state_next = ST_FETCH;
        end else if (status.out_free) begin
          cmd.push = 1'b1;
          if (status.dfs) begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/gsbd_datapath.sv -----
// ----------------------------------------------------------------------------
// gsbd_datapath: graph search datapath
// Adjacency and pending-node memories, visited marks, neighbor select,
// config registers and the result register.
// ----------------------------------------------------------------------------
module gsbd_datapath #(
  parameter int MAX_NODES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [gsbd_pkg::CFG_W-1:0]    cfg_data,
  input  logic [gsbd_pkg::NODE_W-1:0]   row_index,
  input  logic [gsbd_pkg::ROW_W-1:0]    row_bits,
  input  logic [gsbd_pkg::NODE_W-1:0]   start_node,
  input  gsbd_pkg::gsbd_cmd_t           cmd,
  output gsbd_pkg::gsbd_status_t        status,
  input  logic                          res_stall,
  output logic                          res_valid,
  output logic [gsbd_pkg::NODE_W-1:0]   visited_node,
  output logic                          last_visit,
  output logic                          bad_start
);
  import gsbd_pkg::*;

  localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int AW   = $clog2(ROWS);
  localparam int PW   = $clog2(ROWS + 1);
  localparam logic [6:0] MAXN = 7'(MAX_NODES);

  logic [CNT_W-1:0]  node_count;
  logic              search_mode;
  logic [ROW_W-1:0]  adj [ROWS];
  logic [NODE_W-1:0] pend [ROWS];
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [ROW_W-1:0]  visited;
  logic [NODE_W-1:0] pend_q;
  logic [ROW_W-1:0]  row_q;
  logic [NODE_W-1:0] hold_node;

  logic [6:0]        n_eff;
  logic [ROW_W-1:0]  usable;
  logic [ROW_W-1:0]  cand;
  logic [NODE_W-1:0] w_node;
  logic [PW-1:0]     rd_ptr;
  logic              out_free;

  assign n_eff    = ({2'b00, node_count} > MAXN) ? MAXN : {2'b00, node_count};
  assign cand     = row_q & usable & ~visited;
  assign rd_ptr   = search_mode ? (tail - PW'(1)) : head;
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      usable[i] = (7'(i) < n_eff);
    end
  end

  always_comb begin
    w_node = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        w_node = NODE_W'(i);
      end
    end
  end

  always_comb begin
    status.bad_start = ({3'b000, start_node} >= n_eff);
    status.empty     = search_mode ? (tail == '0) : (head == tail);
    status.cand_any  = |cand;
    status.out_free  = out_free;
    status.dfs       = search_mode;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      search_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT:  node_count  <= cfg_data[CNT_W-1:0];
        CFG_SEARCH_MODE: search_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (cmd.load_row && (int'(row_index) < ROWS)) begin
      adj[row_index[AW-1:0]] <= row_bits;
    end
    if (cmd.row_read) begin
      row_q <= adj[pend_q[AW-1:0]];
    end
  end

  // pending-node memory (queue or stack)
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend[0] <= start_node;
    end else if (cmd.push) begin
      pend[tail[AW-1:0]] <= w_node;
    end
    if (cmd.fetch) begin
      pend_q <= pend[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      visited <= '0;
    end else if (cmd.start) begin
      head    <= '0;
      tail    <= PW'(1);
      visited <= ROW_W'(1) << start_node;
    end else begin
      if (cmd.fetch && !search_mode) begin
        head <= head + PW'(1);
      end
      if (cmd.push) begin
        tail    <= tail + PW'(1);
        visited <= visited | (ROW_W'(1) << w_node);
      end else if (cmd.pop) begin
        tail <= tail - PW'(1);
      end
    end
  end

  // held node waits until its successor or the end of search is known
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hold_node <= start_node;
    end else if (cmd.push) begin
      hold_node <= w_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_bad || cmd.push || cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bad) begin
      visited_node <= start_node;
      last_visit   <= 1'b1;
      bad_start    <= 1'b1;
    end else if (cmd.push) begin
      visited_node <= hold_node;
      last_visit   <= 1'b0;
      bad_start    <= 1'b0;
    end else if (cmd.finish) begin
      visited_node <= hold_node;
      last_visit   <= 1'b1;
      bad_start    <= 1'b0;
    end
  end

endmodule

// ----- tb/gsbd_walk_checker.sv -----
// ----------------------------------------------------------------------------
// gsbd_walk_checker: visit order predictor and scoreboard for graph search
// Watches the register, request and visit channels of the graph search block.
// Every accepted search is expanded into the nodes it should visit, breadth
// first or depth first, and each visit transfer is compared with the oldest
// expected visit. The mismatch count and the number of visits still due are
// handed to the testbench top.
// ----------------------------------------------------------------------------
package gsbd_tb_pkg;

  typedef enum logic {
    WALK_BREADTH = 1'b0,
    WALK_DEPTH   = 1'b1
  } walk_mode_t;

endpackage

module gsbd_walk_checker
  import gsbd_pkg::*;
  import gsbd_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic              req_type,
  input  logic [NODE_W-1:0] row_index,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic [NODE_W-1:0] start_node,
  input  logic              res_valid,
  input  logic              res_stall,
  input  logic [NODE_W-1:0] visited_node,
  input  logic              last_visit,
  input  logic              bad_start,
  output int                mismatches,
  output int                visits_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 16;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              bad;
  } visit_t;

  logic [ROW_W-1:0] adj_rows [NODES];
  logic [CNT_W-1:0] node_count;
  walk_mode_t       walk_mode;
  visit_t           visit_order[$];

  function automatic void walk_graph(input logic [NODE_W-1:0] root);
    int n_used;
    int pick;
    logic [ROW_W-1:0] in_range;
    logic [ROW_W-1:0] seen;
    logic [ROW_W-1:0] row;
    logic [NODE_W-1:0] v;
    logic [NODE_W-1:0] frontier[$];
    logic [NODE_W-1:0] order[$];
    n_used = (node_count > NODES) ? NODES : int'(node_count);
    if (int'(root) >= n_used) begin
      visit_order.push_back('{node: root, last: 1'b1, bad: 1'b1});
      return;
    end
    in_range = ROW_W'((17'd1 << n_used) - 17'd1);
    seen = '0;
    seen[root] = 1'b1;
    order.push_back(root);
    frontier.push_back(root);
    while (frontier.size() > 0) begin
      if (walk_mode == WALK_BREADTH) begin
        v = frontier.pop_front();
        row = adj_rows[v] & in_range & ~seen;
        for (int w = 0; w < NODES; w++) begin
          if (row[w]) begin
            seen[w] = 1'b1;
            frontier.push_back(NODE_W'(w));
            order.push_back(NODE_W'(w));
          end
        end
      end else begin
        v = frontier[$];
        row = adj_rows[v] & in_range & ~seen;
        if (row == '0) begin
          void'(frontier.pop_back());
        end else begin
          pick = 0;
          for (int w = NODES - 1; w >= 0; w--) begin
            if (row[w]) pick = w;
          end
          seen[pick] = 1'b1;
          frontier.push_back(NODE_W'(pick));
          order.push_back(NODE_W'(pick));
        end
      end
    end
    foreach (order[i]) begin
      visit_order.push_back('{node: order[i], last: (i == order.size() - 1), bad: 1'b0});
    end
  endfunction

  always @(posedge clk) begin
    visit_t got;
    visit_t want;
    if (rst) begin
      node_count = NODE_COUNT_RST;
      walk_mode = WALK_BREADTH;
      visit_order.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) node_count = cfg_data;
        else walk_mode = walk_mode_t'(cfg_data[0]);
      end
      if (res_valid && !res_stall) begin
        got = '{node: visited_node, last: last_visit, bad: bad_start};
        if (visit_order.size() == 0) begin
          $display("%0t: unexpected visit transfer: node %0d last %0b bad %0b",
                   $time, got.node, got.last, got.bad);
          mismatches++;
        end else begin
          want = visit_order.pop_front();
          if (got.node !== want.node || got.last !== want.last || got.bad !== want.bad) begin
            $display("%0t: visit mismatch: expected node %0d last %0b bad %0b, %s",
                     $time, want.node, want.last, want.bad, "got:");
            $display("%0t:   actual node %0d last %0b bad %0b",
                     $time, got.node, got.last, got.bad);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req_type == REQ_LOAD) adj_rows[row_index] = row_bits;
        else walk_graph(start_node);
      end
    end
    visits_due = visit_order.size();
  end

endmodule

// ----- tb/tb_graph_search_bfs_dfs.sv -----
// ----------------------------------------------------------------------------
// tb_graph_search_bfs_dfs: testbench for the graph search block
// Loads every adjacency row, runs directed searches over both walk orders,
// bad start nodes and node count extremes, then random loads and searches
// across several register settings with random idling on both channels and
// one long output hold-off. Checking is done by gsbd_walk_checker.
// ----------------------------------------------------------------------------
module tb_graph_search_bfs_dfs;
  timeunit 1ns;
  timeprecision 1ps;

  import gsbd_pkg::*;
  import gsbd_tb_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 22;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] row;
    logic [ROW_W-1:0]  bits;
    logic [NODE_W-1:0] root;
  } graph_req_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [0:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              req_valid;
  logic              req_stall;
  logic              req_type;
  logic [NODE_W-1:0] row_index;
  logic [ROW_W-1:0]  row_bits;
  logic [NODE_W-1:0] start_node;
  logic              res_valid;
  logic              res_stall;
  logic [NODE_W-1:0] visited_node;
  logic              last_visit;
  logic              bad_start;

  int   mismatches;
  int   visits_due;
  logic req_gaps;
  logic res_gaps;
  logic squeeze;

  always #5 clk = ~clk;

  graph_search_bfs_dfs uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .row_index(row_index),
    .row_bits(row_bits), .start_node(start_node),
    .res_valid(res_valid), .res_stall(res_stall),
    .visited_node(visited_node), .last_visit(last_visit), .bad_start(bad_start)
  );

  gsbd_walk_checker walk_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .row_index(row_index),
    .row_bits(row_bits), .start_node(start_node),
    .res_valid(res_valid), .res_stall(res_stall),
    .visited_node(visited_node), .last_visit(last_visit), .bad_start(bad_start),
    .mismatches(mismatches), .visits_due(visits_due)
  );

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer(input graph_req_t r);
    while (req_gaps && $urandom_range(99) < 28) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= r.kind;
    row_index  <= r.row;
    row_bits   <= r.bits;
    start_node <= r.root;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_row(input logic [NODE_W-1:0] idx, input logic [ROW_W-1:0] bits);
    offer('{kind: REQ_LOAD, row: idx, bits: bits, root: NODE_W'($urandom)});
  endtask

  task automatic search_from(input logic [NODE_W-1:0] root);
    offer('{kind: REQ_SEARCH, row: NODE_W'($urandom), bits: ROW_W'($urandom), root: root});
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    req_valid <= 1'b0;
    while (visits_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_walk(input walk_mode_t walk);
    logic [CFG_W-1:0] word;
    word = CFG_W'($urandom);
    word[0] = walk;
    set_reg(CFG_SEARCH_MODE, word);
  endtask

  function automatic graph_req_t pick_item(input int n_used);
    graph_req_t r;
    r.kind = ($urandom_range(99) < 35) ? REQ_LOAD : REQ_SEARCH;
    r.row = NODE_W'($urandom);
    case ($urandom_range(3))
      0: r.bits = ROW_W'($urandom);
      1: r.bits = ROW_W'($urandom & $urandom & $urandom);
      2: r.bits = ROW_W'(1 << $urandom_range(15)) | ROW_W'(1 << $urandom_range(15));
      default: r.bits = ROW_W'($urandom | $urandom);
    endcase
    if (n_used > 0 && $urandom_range(99) < 85) r.root = NODE_W'($urandom_range(n_used - 1));
    else r.root = NODE_W'($urandom);
    return r;
  endfunction

  // visit side: random stall, long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= res_gaps && ($urandom_range(99) < 28);
      end
    end
  end

  initial begin
    #5ms;
    $display("graph_search_bfs_dfs verification failed");
    $finish;
  end

  initial begin
    int counts[PHASES];
    int n;
    walk_mode_t walk;
    graph_req_t item;
    counts = '{16, 16, 5, 5, 1, 0, 31, 0, 24};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req_type = REQ_LOAD;
    row_index = '0;
    row_bits = '0;
    start_node = '0;
    req_gaps = 1'b1;
    res_gaps = 1'b1;
    squeeze = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every row is loaded before any search can read it
    load_row(0, 16'hFFFF);
    load_row(15, 16'h0000);
    load_row(1, 16'h8001);
    for (int r = 2; r < 15; r++) load_row(NODE_W'(r), ROW_W'($urandom & $urandom));
    search_from(0);
    search_from(15);
    search_from(1);
    set_walk(WALK_DEPTH);
    search_from(0);
    search_from(1);
    set_reg(CFG_NODE_COUNT, 5'd1);
    search_from(0);
    search_from(1);
    search_from(15);
    set_reg(CFG_NODE_COUNT, 5'd0);
    search_from(0);
    set_reg(CFG_NODE_COUNT, 5'd31);
    search_from(15);

    for (int p = 0; p < PHASES; p++) begin
      n = (p == 7) ? $urandom_range(2, 15) : counts[p];
      walk = (p == 7) ? walk_mode_t'($urandom_range(1)) : walk_mode_t'(p[0]);
      set_reg(CFG_NODE_COUNT, CFG_W'(n));
      set_walk(walk);
      req_gaps = (p != 1);
      res_gaps = (p != 1);
      if (p == 0) begin
        squeeze = 1'b1;
        req_gaps = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        item = pick_item((n > 16) ? 16 : n);
        if (p == 0 && i < 14) item.kind = REQ_SEARCH;
        if (p == 0 && i == 14) req_gaps = 1'b1;
        offer(item);
      end
    end

    req_valid <= 1'b0;
    while (visits_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("graph_search_bfs_dfs verification clean");
    end else begin
      $display("graph_search_bfs_dfs verification failed");
    end
    $finish;
  end

endmodule
